@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the MSA image decoder.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond)

`endif

`endif

@@ rtl/msa_rle_pkg.sv @@
// Constants and types for the MSA disk image RLE decoder.
// No dependencies; imported by the decoder top level.
`timescale 1ns / 1ps

package msa_rle_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_BITS  = $clog2(SECTOR_BYTES + 1);
    // A full track holds up to SECTOR_BYTES * 65535 bytes.
    localparam int TRACK_W      = 16 + SECTOR_BITS;

    localparam logic [15:0] MSA_ID   = 16'h0E0F;
    localparam logic [7:0]  RLE_MARK = 8'hE5;

    // Header byte indexes that complete a big-endian word.
    localparam logic [3:0] HDR_IDX_ID    = 4'd1;
    localparam logic [3:0] HDR_IDX_SPT   = 4'd3;
    localparam logic [3:0] HDR_IDX_SIDES = 4'd5;
    localparam logic [3:0] HDR_IDX_FIRST = 4'd7;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_ID  = 2'd1,
        STATUS_CLAMPED = 2'd2
    } status_t;

endpackage

@@ rtl/msa_disk_image_rle_decoder_unit.sv @@
// MSA image decoder: one file byte in, at most one run (value, count, offset) out.
// Depends on msa_rle_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Accepts one file byte per clock cycle while the result register is not held; the run
// for a byte goes from the input register through the parse logic into the result
// register. The parse step updates all header, track and position state from one byte.
// A held result stalls the input register and, through it, the input side.
module msa_disk_image_rle_decoder_unit
    import msa_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        start_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  run_value,
    output logic [15:0] run_count,
    output logic [31:0] dest_offset,
    output logic        track_end,
    output logic        image_end,
    output logic [1:0]  status
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_RAW,
        PH_CODE,
        PH_RUN_VAL,
        PH_RUN_HI,
        PH_RUN_LO,
        PH_DONE,
        PH_STOPPED
    } phase_t;

    // input register
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_sof_reg;

    // parse state
    phase_t            phase_reg, phase_next;
    logic [7:0]        whb_reg, whb_next;
    logic [3:0]        idx_reg, idx_next;
    logic [15:0]       spt_reg, spt_next;
    logic [15:0]       sides_reg, sides_next;
    logic [15:0]       first_reg, first_next;
    logic [15:0]       last_reg, last_next;
    logic [15:0]       track_reg, track_next;
    logic [15:0]       side_reg, side_next;
    logic              raw_reg, raw_next;
    logic [TRACK_W-1:0] done_reg, done_next;
    logic [7:0]        pend_reg, pend_next;
    logic [31:0]       pos_reg, pos_next;

    // result register
    logic              out_valid_reg;
    logic [7:0]        out_value_reg;
    logic [15:0]       out_count_reg;
    logic [31:0]       out_offset_reg;
    logic              out_tend_reg;
    logic              out_iend_reg;
    status_t           out_status_reg;

    // parse step
    logic              advance;
    phase_t            ph_eff;
    logic [3:0]        idx_eff;
    logic [31:0]       pos_eff;
    logic [15:0]       word;
    logic [TRACK_W-1:0] track_bytes;
    logic [TRACK_W-1:0] left;
    logic [TRACK_W-1:0] done_sum;
    logic              run_go;
    logic [7:0]        run_val;
    logic [15:0]       run_cnt;
    status_t           run_st;
    logic              step_side;
    logic              res_go;
    logic [7:0]        res_value;
    logic [15:0]       res_count;
    logic [31:0]       res_offset;
    logic              res_tend;
    logic              res_iend;
    status_t           res_status;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    assign track_bytes = TRACK_W'(spt_reg) * TRACK_W'(SECTOR_BYTES);
    assign left        = track_bytes - done_reg;
    assign word        = {whb_reg, s1_byte_reg};

    always_comb
    begin
        // start of file resets phase, header index and position before this byte is taken
        ph_eff  = s1_sof_reg ? PH_HEADER : phase_reg;
        idx_eff = s1_sof_reg ? 4'd0 : idx_reg;
        pos_eff = s1_sof_reg ? 32'd0 : pos_reg;

        phase_next = ph_eff;
        whb_next   = whb_reg;
        idx_next   = idx_eff;
        spt_next   = spt_reg;
        sides_next = sides_reg;
        first_next = first_reg;
        last_next  = last_reg;
        track_next = track_reg;
        side_next  = side_reg;
        raw_next   = raw_reg;
        done_next  = done_reg;
        pend_next  = pend_reg;
        pos_next   = pos_eff;

        run_go     = 1'b0;
        run_val    = s1_byte_reg;
        run_cnt    = 16'd1;
        run_st     = STATUS_OK;
        step_side  = 1'b0;
        done_sum   = '0;

        res_go     = 1'b0;
        res_value  = 8'd0;
        res_count  = 16'd0;
        res_offset = pos_eff;
        res_tend   = 1'b0;
        res_iend   = 1'b0;
        res_status = STATUS_OK;

        case (ph_eff)
            PH_HEADER:
            begin
                idx_next = idx_eff + 4'd1;
                if (!idx_eff[0])
                begin
                    whb_next = s1_byte_reg;
                end
                else if (idx_eff == HDR_IDX_ID)
                begin
                    if (word != MSA_ID)
                    begin
                        phase_next = PH_STOPPED;
                        res_go     = 1'b1;
                        res_offset = 32'd0;
                        res_iend   = 1'b1;
                        res_status = STATUS_BAD_ID;
                    end
                end
                else if (idx_eff == HDR_IDX_SPT)
                begin
                    spt_next = word;
                end
                else if (idx_eff == HDR_IDX_SIDES)
                begin
                    sides_next = word;
                end
                else if (idx_eff == HDR_IDX_FIRST)
                begin
                    first_next = word;
                end
                else
                begin
                    last_next = word;
                    idx_next  = 4'd0;
                    if (first_reg > word)
                    begin
                        phase_next = PH_DONE;
                        res_go     = 1'b1;
                        res_iend   = 1'b1;
                    end
                    else
                    begin
                        track_next = first_reg;
                        side_next  = 16'd0;
                        phase_next = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI:
            begin
                whb_next   = s1_byte_reg;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                done_next = '0;
                raw_next  = (TRACK_W'(word) == track_bytes);
                if (track_bytes == '0)
                begin
                    // empty track: report it and move on
                    res_go    = 1'b1;
                    res_tend  = 1'b1;
                    step_side = 1'b1;
                end
                else
                begin
                    phase_next = (TRACK_W'(word) == track_bytes) ? PH_RAW : PH_CODE;
                end
            end
            PH_RAW:
            begin
                run_go = 1'b1;
            end
            PH_CODE:
            begin
                if (s1_byte_reg != RLE_MARK)
                begin
                    run_go = 1'b1;
                end
                else
                begin
                    phase_next = PH_RUN_VAL;
                end
            end
            PH_RUN_VAL:
            begin
                pend_next  = s1_byte_reg;
                phase_next = PH_RUN_HI;
            end
            PH_RUN_HI:
            begin
                whb_next   = s1_byte_reg;
                phase_next = PH_RUN_LO;
            end
            PH_RUN_LO:
            begin
                phase_next = PH_CODE;
                run_val    = pend_reg;
                run_cnt    = word;
                // clamp a run that would pass the track end
                if (TRACK_W'(word) > left)
                begin
                    run_cnt = left[15:0];
                    run_st  = STATUS_CLAMPED;
                end
                run_go = (run_cnt != 16'd0);
            end
            default:
            begin
                // done or stopped: drop bytes until start of file
            end
        endcase

        if (run_go)
        begin
            done_sum   = done_reg + TRACK_W'(run_cnt);
            done_next  = done_sum;
            pos_next   = pos_eff + 32'(run_cnt);
            res_go     = 1'b1;
            res_value  = run_val;
            res_count  = run_cnt;
            res_status = run_st;
            res_tend   = (done_sum >= track_bytes);
            step_side  = (done_sum >= track_bytes);
        end

        if (step_side)
        begin
            phase_next = PH_LEN_HI;
            if (side_reg != sides_reg)
            begin
                side_next = side_reg + 16'd1;
            end
            else
            begin
                side_next = 16'd0;
                if (track_reg == last_reg)
                begin
                    phase_next = PH_DONE;
                    res_iend   = 1'b1;
                end
                else
                begin
                    track_next = track_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_byte_reg    <= 8'd0;
            s1_sof_reg     <= 1'b0;
            phase_reg      <= PH_HEADER;
            whb_reg        <= 8'd0;
            idx_reg        <= 4'd0;
            spt_reg        <= 16'd0;
            sides_reg      <= 16'd0;
            first_reg      <= 16'd0;
            last_reg       <= 16'd0;
            track_reg      <= 16'd0;
            side_reg       <= 16'd0;
            raw_reg        <= 1'b0;
            done_reg       <= '0;
            pend_reg       <= 8'd0;
            pos_reg        <= 32'd0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= 8'd0;
            out_count_reg  <= 16'd0;
            out_offset_reg <= 32'd0;
            out_tend_reg   <= 1'b0;
            out_iend_reg   <= 1'b0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            // input register: load on accept, drain on advance
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= stream_byte;
                s1_sof_reg   <= start_of_file;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg <= phase_next;
                whb_reg   <= whb_next;
                idx_reg   <= idx_next;
                spt_reg   <= spt_next;
                sides_reg <= sides_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                track_reg <= track_next;
                side_reg  <= side_next;
                raw_reg   <= raw_next;
                done_reg  <= done_next;
                pend_reg  <= pend_next;
                pos_reg   <= pos_next;
            end

            if (advance && res_go)
            begin
                out_valid_reg  <= 1'b1;
                out_value_reg  <= res_value;
                out_count_reg  <= res_count;
                out_offset_reg <= res_offset;
                out_tend_reg   <= res_tend;
                out_iend_reg   <= res_iend;
                out_status_reg <= res_status;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign run_value   = out_value_reg;
    assign run_count   = out_count_reg;
    assign dest_offset = out_offset_reg;
    assign track_end   = out_tend_reg;
    assign image_end   = out_iend_reg;
    assign status      = out_status_reg;

    `ASSERT_NEVER(a_quiet_after_end, clk, rst_n,
        advance && !s1_sof_reg && res_go &&
        (phase_reg == PH_DONE || phase_reg == PH_STOPPED))

    `ASSERT_CLK(a_done_within_track, clk, rst_n,
        (phase_reg == PH_RAW || phase_reg == PH_CODE || phase_reg == PH_RUN_VAL ||
         phase_reg == PH_RUN_HI || phase_reg == PH_RUN_LO) |-> (done_reg <= track_bytes))

    `ASSERT_CLK(a_image_end_stops, clk, rst_n,
        (advance && res_go && res_iend && res_status == STATUS_OK) |=>
        (phase_reg == PH_DONE))

    `ASSERT_CLK(a_stall_only_on_full, clk, rst_n,
        in_stall |-> (out_valid_reg && out_stall && s1_valid_reg))

    `ASSERT_CLK(a_raw_phase_on_raw_track, clk, rst_n,
        (phase_reg == PH_RAW) |-> raw_reg)

endmodule

@@ sim/msa_run_tracker.sv @@
// Run tracker for the MSA image decoder: follows both channels, predicts the runs
// from the accepted file bytes and compares every accepted run field by field.
// Depends on msa_rle_pkg.
`timescale 1ns / 1ps

module msa_run_tracker
    import msa_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        start_of_file,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  run_value,
    input  logic [15:0] run_count,
    input  logic [31:0] dest_offset,
    input  logic        track_end,
    input  logic        image_end,
    input  logic [1:0]  status,
    output int          pending,
    output int          fails
);

    typedef enum logic [3:0] {
        P_HEADER,
        P_LEN_HI,
        P_LEN_LO,
        P_RAW,
        P_CODE,
        P_RUN_VALUE,
        P_COUNT_HI,
        P_COUNT_LO,
        P_DONE,
        P_HALTED
    } phase_t;

    typedef struct {
        logic [7:0]  value;
        logic [15:0] count;
        logic [31:0] offset;
        logic        tend;
        logic        iend;
        status_t     st;
    } run_t;

    run_t        expected_runs[$];
    run_t        want;

    phase_t      phase;
    logic [7:0]  hi_byte;
    logic [3:0]  hdr_idx;
    logic [15:0] spt;
    logic [15:0] sides_m1;
    logic [15:0] trk_first;
    logic [15:0] trk_last;
    logic [15:0] trk;
    logic [15:0] side;
    logic        raw_mode;
    logic [31:0] track_fill;
    logic [7:0]  run_byte;
    logic [31:0] out_pos;

    function automatic void clear_state();
        phase      = P_HEADER;
        hi_byte    = '0;
        hdr_idx    = '0;
        spt        = '0;
        sides_m1   = '0;
        trk_first  = '0;
        trk_last   = '0;
        trk        = '0;
        side       = '0;
        raw_mode   = 1'b0;
        track_fill = '0;
        run_byte   = '0;
        out_pos    = '0;
    endfunction

    function automatic logic [31:0] track_size();
        return {16'd0, spt} * SECTOR_BYTES;
    endfunction

    function automatic void push_run(logic [7:0] v, logic [15:0] c, logic [31:0] off,
                                     logic te, logic ie, status_t st);
        expected_runs.push_back('{v, c, off, te, ie, st});
    endfunction

    // Step to the next track side; returns 1 once the last one is finished.
    function automatic logic step_side();
        phase = P_LEN_HI;
        if (side != sides_m1) begin
            side = side + 16'd1;
            return 1'b0;
        end
        side = '0;
        if (trk == trk_last) begin
            phase = P_DONE;
            return 1'b1;
        end
        trk = trk + 16'd1;
        return 1'b0;
    endfunction

    function automatic void emit_run(logic [7:0] v, logic [31:0] c, status_t st);
        logic [31:0] at;
        logic        te;
        logic        ie;
        at = out_pos;
        out_pos = out_pos + c;
        track_fill = track_fill + c;
        te = (track_fill >= track_size());
        ie = te ? step_side() : 1'b0;
        push_run(v, c[15:0], at, te, ie, st);
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic sof);
        logic [15:0] word;
        logic [3:0]  idx;
        logic [31:0] left;
        logic [31:0] cnt;
        status_t     st;
        logic        ie;
        if (sof)
            clear_state();
        word = {hi_byte, b};
        case (phase)
            P_HEADER:
            begin
                idx = hdr_idx;
                hdr_idx = hdr_idx + 4'd1;
                if (!idx[0])
                    hi_byte = b;
                else if (idx == HDR_IDX_ID)
                begin
                    if (word != MSA_ID)
                    begin
                        phase = P_HALTED;
                        push_run('0, '0, '0, 1'b0, 1'b1, STATUS_BAD_ID);
                    end
                end
                else if (idx == HDR_IDX_SPT)
                    spt = word;
                else if (idx == HDR_IDX_SIDES)
                    sides_m1 = word;
                else if (idx == HDR_IDX_FIRST)
                    trk_first = word;
                else
                begin
                    trk_last = word;
                    hdr_idx = '0;
                    if (trk_first > trk_last)
                    begin
                        phase = P_DONE;
                        push_run('0, '0, out_pos, 1'b0, 1'b1, STATUS_OK);
                    end
                    else
                    begin
                        trk = trk_first;
                        side = '0;
                        phase = P_LEN_HI;
                    end
                end
            end
            P_LEN_HI:
            begin
                hi_byte = b;
                phase = P_LEN_LO;
            end
            P_LEN_LO:
            begin
                track_fill = '0;
                raw_mode = ({16'd0, word} == track_size());
                if (track_size() == 0)
                begin
                    ie = step_side();
                    push_run('0, '0, out_pos, 1'b1, ie, STATUS_OK);
                end
                else
                    phase = raw_mode ? P_RAW : P_CODE;
            end
            P_RAW:
                emit_run(b, 32'd1, STATUS_OK);
            P_CODE:
            begin
                if (b != RLE_MARK)
                    emit_run(b, 32'd1, STATUS_OK);
                else
                    phase = P_RUN_VALUE;
            end
            P_RUN_VALUE:
            begin
                run_byte = b;
                phase = P_COUNT_HI;
            end
            P_COUNT_HI:
            begin
                hi_byte = b;
                phase = P_COUNT_LO;
            end
            P_COUNT_LO:
            begin
                left = track_size() - track_fill;
                cnt = {16'd0, word};
                st = STATUS_OK;
                phase = P_CODE;
                // clamp a run that would pass the end of the track
                if (cnt > left)
                begin
                    cnt = left;
                    st = STATUS_CLAMPED;
                end
                if (cnt != 0)
                    emit_run(run_byte, cnt, st);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
        if (got !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_runs.delete();
            pending = 0;
            fails = 0;
        end
        else
        begin
            // compare first: a byte accepted at this edge cannot have its run out yet
            if (out_valid && !out_stall)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("run at offset 0x%0h with none expected", dest_offset);
                    fails++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    check_field("run_value", want.value, run_value);
                    check_field("run_count", want.count, run_count);
                    check_field("dest_offset", want.offset, dest_offset);
                    check_field("track_end", want.tend, track_end);
                    check_field("image_end", want.iend, image_end);
                    check_field("status", want.st, status);
                end
            end
            if (in_valid && !in_stall)
                decode_byte(stream_byte, start_of_file);
            pending = expected_runs.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// Top of the MSA image decoder test: builds image files byte by byte, drives both
// channels with random gaps and stalls, and reports the verdict from msa_run_tracker.
// Depends on msa_rle_pkg, msa_run_tracker and msa_disk_image_rle_decoder_unit.
`timescale 1ns / 1ps

module testbench;
    import msa_rle_pkg::*;

    localparam int ITEM_TARGET    = 1300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_CODES      = 60;
    localparam int MAX_SIDES      = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } file_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = '0;
    logic        start_of_file = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  run_value;
    logic [15:0] run_count;
    logic [31:0] dest_offset;
    logic        track_end;
    logic        image_end;
    logic [1:0]  status;

    int          pending;
    int          fails;
    file_byte_t  file_bytes[$];
    int          bytes_sent = 0;
    bit          burst = 1'b0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          idle_cycles = 0;

    msa_disk_image_rle_decoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .stream_byte   (stream_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .run_value     (run_value),
        .run_count     (run_count),
        .dest_offset   (dest_offset),
        .track_end     (track_end),
        .image_end     (image_end),
        .status        (status)
    );

    msa_run_tracker run_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .stream_byte   (stream_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .run_value     (run_value),
        .run_count     (run_count),
        .dest_offset   (dest_offset),
        .track_end     (track_end),
        .image_end     (image_end),
        .status        (status),
        .pending       (pending),
        .fails         (fails)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void put_byte(logic [7:0] b, logic sof);
        file_bytes.push_back({b, sof});
    endfunction

    function automatic void put_word(logic [15:0] w);
        put_byte(w[15:8], 1'b0);
        put_byte(w[7:0], 1'b0);
    endfunction

    function automatic void put_noise(int n, int sof_pct);
        repeat (n)
            put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < sof_pct);
    endfunction

    function automatic void put_header(logic [15:0] id, logic [15:0] spt, logic [15:0] sides,
                                       logic [15:0] first, logic [15:0] last);
        put_byte(id[15:8], 1'b1);
        put_byte(id[7:0], 1'b0);
        put_word(spt);
        put_word(sides);
        put_word(first);
        put_word(last);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Fill one RLE track side with literals and runs; cut ends the image early.
    function automatic void build_rle_track(logic [31:0] size, inout int codes, output bit cut);
        logic [31:0] fill;
        logic [31:0] left;
        logic [31:0] cnt;
        logic [7:0]  v;
        int          r;
        fill = '0;
        cut = 1'b0;
        while (fill < size && !cut)
        begin
            left = size - fill;
            if (codes >= MAX_CODES || $urandom_range(0, 99) < 2)
                cut = 1'b1;
            else
            begin
                codes++;
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    v = 8'($urandom_range(0, 255));
                    if (v == RLE_MARK)
                        v = v - 8'd1;
                    put_byte(v, 1'b0);
                    fill = fill + 32'd1;
                end
                else
                begin
                    if (r < 70)
                        cnt = $urandom_range(1, 8);
                    else if (r < 78)
                        cnt = left;
                    else if (r < 88)
                        cnt = left + $urandom_range(1, 16);
                    else if (r < 96)
                        cnt = $urandom_range(0, 65535);
                    else
                        cnt = '0;
                    if (cnt > 32'hFFFF)
                        cnt = 32'hFFFF;
                    put_byte(RLE_MARK, 1'b0);
                    put_byte(8'($urandom_range(0, 255)), 1'b0);
                    put_word(cnt[15:0]);
                    fill = fill + ((cnt > left) ? left : cnt);
                end
            end
        end
    endfunction

    function automatic void build_image();
        logic [15:0] id;
        logic [15:0] spt;
        logic [15:0] sides;
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] trk;
        logic [15:0] side;
        logic [15:0] len;
        logic [31:0] size;
        int          r;
        int          n;
        int          codes;
        int          nsides;
        bit          cut;
        bit          done;
        bit          raw;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            put_noise($urandom_range(1, 8), 20);
            return;
        end
        if (r < 11)
        begin
            id = 16'($urandom_range(0, 65535));
            if (id == MSA_ID)
                id = id ^ 16'h0001;
            put_byte(id[15:8], 1'b1);
            put_byte(id[7:0], 1'b0);
            put_noise($urandom_range(0, 3), 0);
            return;
        end

        r = $urandom_range(0, 99);
        if (r < 10)
            spt = '0;
        else if (r < 75)
            spt = 16'd1;
        else if (r < 87)
            spt = 16'($urandom_range(2, 4));
        else if (r < 95)
            spt = 16'($urandom_range(5, 127));
        else
            spt = 16'($urandom_range(128, 65535));

        r = $urandom_range(0, 99);
        if (r < 60)
            sides = '0;
        else if (r < 90)
            sides = 16'd1;
        else
            sides = 16'($urandom_range(2, 65535));

        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            first = 16'($urandom_range(1, 65535));
            last = 16'($urandom_range(0, first - 1));
        end
        else if (r < 60)
        begin
            first = 16'($urandom_range(0, 65535));
            last = first;
        end
        else
        begin
            first = 16'($urandom_range(0, 65534));
            last = first + 16'd1;
        end

        put_header(MSA_ID, spt, sides, first, last);
        if (first > last)
        begin
            put_noise($urandom_range(0, 2), 0);
            return;
        end

        size = {16'd0, spt} * SECTOR_BYTES;
        trk = first;
        side = '0;
        codes = 0;
        nsides = 0;
        cut = 1'b0;
        done = 1'b0;
        while (!cut && !done)
        begin
            if (nsides >= MAX_SIDES)
                cut = 1'b1;
            else
            begin
                raw = (spt == 16'd1 && $urandom_range(0, 99) < 8);
                len = 16'($urandom_range(0, 65535));
                if ({16'd0, len} == size)
                    len = len ^ 16'h0001;
                put_word(raw ? size[15:0] : len);
                if (raw)
                begin
                    // a full raw track is costly, so cut half of them short
                    n = $urandom_range(0, 1) ? int'(size) : $urandom_range(1, 30);
                    put_noise(n, 0);
                    cut = (n != int'(size));
                end
                else if (size != 0)
                    build_rle_track(size, codes, cut);
                nsides++;
                if (!cut)
                begin
                    if (side != sides)
                        side = side + 16'd1;
                    else
                    begin
                        side = '0;
                        if (trk == last)
                            done = 1'b1;
                        else
                            trk = trk + 16'd1;
                    end
                end
            end
        end
        // bytes after the image end are ignored
        if (done && $urandom_range(0, 3) == 0)
            put_noise($urandom_range(1, 4), 0);
    endfunction

    task automatic send_all();
        file_byte_t it;
        int         gap;
        while (file_bytes.size() > 0)
        begin
            it = file_bytes.pop_front();
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid = 1'b1;
            stream_byte = it.data;
            start_of_file = it.sof;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
            bytes_sent++;
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // bad identifier
        put_byte(8'h0E, 1'b1);
        put_byte(8'h0E, 1'b0);
        // largest header words, then literals, a maximal run and a zero-count run
        put_header(MSA_ID, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        put_word(16'h0000);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(RLE_MARK, 1'b0);
        put_byte(RLE_MARK, 1'b0);
        put_word(16'hFFFF);
        put_byte(RLE_MARK, 1'b0);
        put_byte(8'h00, 1'b0);
        put_word(16'h0000);
        burst = 1'b1;
        send_all();
        drain();

        hold_requests++;
        while (bytes_sent < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 99) < 30);
            build_image();
            send_all();
            if ($urandom_range(0, 9) == 0)
                drain();
            if (bytes_sent >= ITEM_TARGET / 2 && hold_requests == 1)
                hold_requests++;
        end

        drain();
        repeat (8) @(negedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, quiet stretches, and a long hold on request.
    initial
    begin
        int r;
        int stall_run;
        int quiet_left;
        bit quiet;
        stall_run = 0;
        quiet_left = 0;
        quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_served < hold_requests)
            begin
                holds_served++;
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (quiet_left == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                quiet_left = $urandom_range(50, 300);
            end
            quiet_left--;
            if (stall_run > 0)
            begin
                out_stall = 1'b1;
                stall_run--;
            end
            else if (quiet)
                out_stall = 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    out_stall = 1'b0;
                else
                begin
                    out_stall = 1'b1;
                    stall_run = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
